// ----- hdl/assert_macros.svh -----
// Assertion macros used by the frame buffer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is held.
`define MLFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define MLFB_NEVER(lbl, clk, rst_n, cond, msg) \
  `MLFB_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/mlfb_pkg.sv -----
// Shared types, codes, widths and helpers of the memory LCD frame buffer.
`timescale 1ns / 1ps
package mlfb_pkg;

  // Default geometry.
  localparam int DEF_WIDTH  = 400;
  localparam int DEF_HEIGHT = 240;
  localparam int DEF_STRIDE = 52;

  // Field widths.
  localparam int OP_W      = 3;
  localparam int COL_W     = 9;
  localparam int ROW_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int CURSOR_W  = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = BYTE_W;
  localparam int OUT_TUSER_W = 1;

  // Line layout constants.
  localparam int HDR_BYTES           = 2;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] MODE_BYTE   = 8'h80;
  localparam logic [7:0] PIXEL_MSB   = 8'h80;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 3'd1;
  localparam logic [OP_W-1:0] OP_BYTE  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // What the sequencer has to do for one request.
  typedef enum logic [2:0] {
    K_IGNORE,
    K_WRITE,
    K_READ,
    K_PIXEL,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] mask;
    logic             pix_set;
  } req_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// ----- hdl/mlfb_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module mlfb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [DATA_W-1:0]          wdata,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read data holds while the port is idle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hdl/mlfb_req.sv -----
// Request decode: bounds checks, store address and the load cursor.
`timescale 1ns / 1ps
module mlfb_req #(
  parameter int WIDTH  = mlfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = mlfb_pkg::DEF_HEIGHT,
  parameter int STRIDE = mlfb_pkg::DEF_STRIDE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [mlfb_pkg::OP_W-1:0]            op,
  input  logic [mlfb_pkg::COL_W-1:0]           col,
  input  logic [mlfb_pkg::ROW_W-1:0]           row,
  input  logic [mlfb_pkg::BYTE_W-1:0]          value,
  input  logic                                 restart,
  output mlfb_pkg::req_t                       req,
  output logic [$clog2(HEIGHT*STRIDE)-1:0]     addr
);
  import mlfb_pkg::*;

  localparam int ADDR_W   = $clog2(HEIGHT*STRIDE);
  localparam int STRIDE_W = $clog2(STRIDE+1);
  localparam int SUM_W    = ROW_W + STRIDE_W + 2;
  localparam int LPB      = ((WIDTH/8) < (STRIDE-HDR_BYTES)) ? (WIDTH/8) : (STRIDE-HDR_BYTES);

  logic [ROW_W-1:0]    load_line_r, load_line_nxt;
  logic [CURSOR_W-1:0] load_byte_r, load_byte_nxt;
  logic [ROW_W-1:0]    eff_line;
  logic [CURSOR_W-1:0] eff_byte;
  logic [CURSOR_W:0]   byte_inc;
  logic [ROW_W-1:0]    row_sel;
  logic [COL_W:0]      offset;
  logic [SUM_W-1:0]    sum;
  logic                row_bad;

  assign eff_line = restart ? '0 : load_line_r;
  assign eff_byte = restart ? '0 : load_byte_r;
  assign byte_inc = {1'b0, eff_byte} + (CURSOR_W+1)'(1);
  assign row_bad  = (row >= ROW_W'(HEIGHT));

  // One shared line multiplier: the load cursor line or the requested row.
  assign row_sel = (op == OP_LOAD) ? eff_line : row;
  assign sum     = SUM_W'(row_sel) * SUM_W'(STRIDE) + SUM_W'(offset);
  assign addr    = sum[ADDR_W-1:0];

  always_comb begin
    req.kind    = K_IGNORE;
    req.wdata   = value;
    req.mask    = PIXEL_MSB >> col[2:0];
    req.pix_set = (value != '0);
    offset      = '0;
    unique case (op)
      OP_CLEAR: begin
        req.kind = K_CLEAR;
      end
      OP_PIXEL: begin
        offset = (COL_W+1)'(col[COL_W-1:3]) + (COL_W+1)'(HDR_BYTES);
        if (!(col >= COL_W'(WIDTH) || row_bad || col[COL_W-1:3] >= CURSOR_W'(LPB))) begin
          req.kind = K_PIXEL;
        end
      end
      OP_BYTE: begin
        offset = (COL_W+1)'(col) + (COL_W+1)'(HDR_BYTES);
        if (!(col >= COL_W'(LPB) || row_bad)) begin
          req.kind = K_WRITE;
        end
      end
      OP_LOAD: begin
        offset    = (COL_W+1)'(eff_byte) + (COL_W+1)'(HDR_BYTES);
        req.wdata = flip8(value);
        if (eff_line < ROW_W'(HEIGHT)) begin
          req.kind = K_WRITE;
        end
      end
      OP_READ: begin
        offset = (COL_W+1)'(col);
        if (!(col >= COL_W'(STRIDE) || row_bad)) begin
          req.kind = K_READ;
        end
      end
      default: begin
        req.kind = K_IGNORE;
      end
    endcase
  end

  // Advance the cursor on each load that lands; wrap to the next line.
  always_comb begin
    load_line_nxt = load_line_r;
    load_byte_nxt = load_byte_r;
    if (accept && op == OP_LOAD) begin
      load_line_nxt = eff_line;
      load_byte_nxt = eff_byte;
      if (eff_line < ROW_W'(HEIGHT)) begin
        if (byte_inc >= (CURSOR_W+1)'(LPB)) begin
          load_byte_nxt = '0;
          load_line_nxt = eff_line + ROW_W'(1);
        end else begin
          load_byte_nxt = byte_inc[CURSOR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_line_r <= '0;
      load_byte_r <= '0;
    end else begin
      load_line_r <= load_line_nxt;
      load_byte_r <= load_byte_nxt;
    end
  end

endmodule

// ----- hdl/mlfb_seq.sv -----
// Sequencer: store access, pixel read-modify-write, clear sweep and result register.
`timescale 1ns / 1ps
module mlfb_seq #(
  parameter int HEIGHT = mlfb_pkg::DEF_HEIGHT,
  parameter int STRIDE = mlfb_pkg::DEF_STRIDE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  output logic                                 in_ready,
  input  mlfb_pkg::req_t                       req_in,
  input  logic [$clog2(HEIGHT*STRIDE)-1:0]     req_addr,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mlfb_pkg::BYTE_W-1:0]          out_data,
  output logic                                 out_status,
  output mlfb_pkg::mem_ctl_t                   mem_ctl,
  output logic [$clog2(HEIGHT*STRIDE)-1:0]     mem_addr,
  output logic [mlfb_pkg::BYTE_W-1:0]          mem_wdata,
  input  logic [mlfb_pkg::BYTE_W-1:0]          mem_rdata
);
  import mlfb_pkg::*;
`include "assert_macros.svh"

  localparam int DEPTH  = HEIGHT * STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COLC_W = $clog2(STRIDE);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_RDATA = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  req_t                req_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [COLC_W-1:0]   clr_col_r, clr_col_nxt;
  logic [ROW_W-1:0]    clr_line_r, clr_line_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_free;
  logic                clr_last;
  logic [BYTE_W-1:0]   clr_byte;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_free   = !out_valid_r || out_ready;
  assign clr_last   = (clr_addr_r == ADDR_W'(DEPTH-1));

  // Header bytes at the head of each line, fill elsewhere.
  always_comb begin
    if (clr_col_r == COLC_W'(0)) begin
      clr_byte = MODE_BYTE;
    end else if (clr_col_r == COLC_W'(1)) begin
      clr_byte = flip8(clr_line_r + ROW_W'(1));
    end else begin
      clr_byte = FILL_BYTE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mem_ctl        = '0;
    mem_addr       = addr_r;
    mem_wdata      = req_r.wdata;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    clr_addr_nxt   = clr_addr_r;
    clr_col_nxt    = clr_col_r;
    clr_line_nxt   = clr_line_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_EXEC;
          clr_addr_nxt = '0;
          clr_col_nxt  = '0;
          clr_line_nxt = '0;
        end
      end
      S_EXEC: begin
        unique case (req_r.kind)
          K_IGNORE: begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_status_nxt = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          K_WRITE: begin
            if (out_free) begin
              mem_ctl.en     = 1'b1;
              mem_ctl.we     = 1'b1;
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_status_nxt = 1'b0;
              state_nxt      = S_IDLE;
            end
          end
          K_READ, K_PIXEL: begin
            mem_ctl.en = 1'b1;
            state_nxt  = S_RDATA;
          end
          K_CLEAR: begin
            state_nxt = S_CLEAR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RDATA: begin
        // Read data stays in the RAM output register until the result can go.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          state_nxt      = S_IDLE;
          if (req_r.kind == K_PIXEL) begin
            mem_ctl.en   = 1'b1;
            mem_ctl.we   = 1'b1;
            mem_wdata    = req_r.pix_set ? (mem_rdata | req_r.mask)
                                         : (mem_rdata & ~req_r.mask);
            out_data_nxt = '0;
          end else begin
            out_data_nxt = mem_rdata;
          end
        end
      end
      S_CLEAR: begin
        if (!clr_last || out_free) begin
          mem_ctl.en   = 1'b1;
          mem_ctl.we   = 1'b1;
          mem_addr     = clr_addr_r;
          mem_wdata    = clr_byte;
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
          if (clr_col_r == COLC_W'(STRIDE-1)) begin
            clr_col_nxt  = '0;
            clr_line_nxt = clr_line_r + ROW_W'(1);
          end else begin
            clr_col_nxt = clr_col_r + COLC_W'(1);
          end
          if (clr_last) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = '0;
            out_status_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_in;
      addr_r <= req_addr;
    end
    clr_addr_r   <= clr_addr_nxt;
    clr_col_r    <= clr_col_nxt;
    clr_line_r   <= clr_line_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  `MLFB_NEVER(a_no_write_idle, clk, rst_n, state_r == S_IDLE && mem_ctl.en, "store access while idle")
  `MLFB_ASSERT(a_read_then_data, clk, rst_n, (state_r == S_EXEC && mem_ctl.en && !mem_ctl.we) |=> (state_r == S_RDATA), "store read not followed by data phase")
  `MLFB_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid_r) |-> $past(state_r != S_IDLE), "result raised without work")
  `MLFB_NEVER(a_ignored_zero, clk, rst_n, out_valid_r && out_status_r && out_data_r != '0, "ignored request carries data")

endmodule

// ----- hdl/memory_lcd_frame_buffer.sv -----
// Memory LCD frame buffer: a one-bit-per-pixel frame store kept as lines of
// STRIDE bytes (mode byte, bit-reversed one-based line number, pixel bytes,
// MSB first) in a single-port synchronous RAM of HEIGHT*STRIDE bytes. Every
// request gives exactly one result. Set pixel (read, then modify and write
// back) and read go on to a data state the others skip, bound by the one RAM
// port and its registered read. Clear sweeps the whole store one byte a
// cycle; the last byte waits for a free output register. One request is in
// flight at a time, so a pixel read-modify-write can never overlap another
// access to the same byte. A new request is taken while the previous result
// still waits in the output register. The store holds nothing meaningful
// until the first clear; reads before then return junk.
`timescale 1ns / 1ps
module memory_lcd_frame_buffer #(
  parameter int WIDTH  = mlfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = mlfb_pkg::DEF_HEIGHT,
  parameter int STRIDE = mlfb_pkg::DEF_STRIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // col[8:0], row[16:9], value[24:17], restart[25], zero[31:26]
  input  logic [mlfb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[2:0]
  input  logic [mlfb_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data[7:0]
  output logic [mlfb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[0]
  output logic [mlfb_pkg::OUT_TUSER_W-1:0]    out_tuser
);
  import mlfb_pkg::*;

  localparam int DEPTH  = HEIGHT * STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                in_accept;
  logic [COL_W-1:0]    f_col;
  logic [ROW_W-1:0]    f_row;
  logic [BYTE_W-1:0]   f_value;
  logic                f_restart;
  req_t                req;
  logic [ADDR_W-1:0]   req_addr;
  mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]   mem_addr;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [BYTE_W-1:0]   mem_rdata;
  logic                out_status;

  // Unpack the request fields.
  assign in_accept = in_tvalid && in_tready;
  assign f_col     = in_tdata[8:0];
  assign f_row     = in_tdata[16:9];
  assign f_value   = in_tdata[24:17];
  assign f_restart = in_tdata[25];
  assign out_tuser = OUT_TUSER_W'(out_status);

  // Decode the request: bounds, store address and load cursor.
  mlfb_req #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .STRIDE (STRIDE)
  ) u_req (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .op      (in_tuser),
    .col     (f_col),
    .row     (f_row),
    .value   (f_value),
    .restart (f_restart),
    .req     (req),
    .addr    (req_addr)
  );

  // Drive the store and hold the result until it is taken.
  mlfb_seq #(
    .HEIGHT (HEIGHT),
    .STRIDE (STRIDE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .in_ready   (in_tready),
    .req_in     (req),
    .req_addr   (req_addr),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_status (out_status),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // Frame store.
  mlfb_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_ctl.en),
    .we    (mem_ctl.we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ----- verif/tb_memory_lcd_frame_buffer.sv -----
// Self-checking testbench for the memory LCD frame buffer: directed and random requests.
`timescale 1ns / 1ps
module tb_memory_lcd_frame_buffer;
  import mlfb_pkg::*;

  // Geometry of the instance under test and what follows from it.
  localparam int WIDTH       = DEF_WIDTH;
  localparam int HEIGHT      = DEF_HEIGHT;
  localparam int STRIDE      = DEF_STRIDE;
  localparam int STORE_DEPTH = HEIGHT * STRIDE;
  // Pixel bytes per line never spill past the end of the line.
  localparam int PIX_BYTES   = (WIDTH / 8 < STRIDE - HDR_BYTES) ? WIDTH / 8 : STRIDE - HDR_BYTES;

  // Op codes the block does not define; they must come back as ignored.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Status codes carried on out_tuser.
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef struct {
    int unsigned     seq;
    logic [OP_W-1:0] op;
    logic [7:0]      read_data;
    logic            status;
  } reply_t;

  // Mirror of the frame store and load cursor; holds the replies still owed.
  class lcd_frame_mirror;
    logic [7:0]  store [STORE_DEPTH];
    int unsigned cur_line;
    int unsigned cur_byte;
    int unsigned seq;
    int unsigned errors;
    reply_t      due_replies [$];

    function new();
      cur_line = 0;
      cur_byte = 0;
      seq      = 0;
      errors   = 0;
    endfunction

    function logic [7:0] mirror_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
        r[7 - k] = v[k];
      end
      return r;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    // Apply one accepted request to the mirror and queue the reply it owes.
    function void take_request(input logic [OP_W-1:0] op, input logic [8:0] col,
                               input logic [7:0] row, input logic [7:0] value,
                               input logic restart);
      reply_t      rep;
      int unsigned idx;
      logic [7:0]  mask;
      rep.seq       = seq;
      rep.op        = op;
      rep.read_data = 8'h00;
      rep.status    = ST_DONE;
      seq++;
      case (op)
        OP_CLEAR: begin
          for (int i = 0; i < STORE_DEPTH; i++) store[i] = FILL_BYTE;
          for (int ln = 0; ln < HEIGHT; ln++) begin
            store[ln * STRIDE]     = MODE_BYTE;
            store[ln * STRIDE + 1] = mirror_bits(8'(ln + 1));
          end
        end
        OP_PIXEL: begin
          if (col >= WIDTH || row >= HEIGHT || (col >> 3) >= PIX_BYTES) begin
            rep.status = ST_IGNORED;
          end else begin
            idx  = row * STRIDE + (col >> 3) + HDR_BYTES;
            mask = PIXEL_MSB >> col[2:0];
            store[idx] = (value != 0) ? (store[idx] | mask) : (store[idx] & ~mask);
          end
        end
        OP_BYTE: begin
          if (col >= PIX_BYTES || row >= HEIGHT) rep.status = ST_IGNORED;
          else store[row * STRIDE + col + HDR_BYTES] = value;
        end
        OP_LOAD: begin
          if (restart) begin
            cur_line = 0;
            cur_byte = 0;
          end
          if (cur_line >= HEIGHT) begin
            rep.status = ST_IGNORED;
          end else begin
            store[cur_line * STRIDE + cur_byte + HDR_BYTES] = mirror_bits(value);
            cur_byte++;
            if (cur_byte >= PIX_BYTES) begin
              cur_byte = 0;
              cur_line++;
            end
          end
        end
        OP_READ: begin
          if (col >= STRIDE || row >= HEIGHT) rep.status = ST_IGNORED;
          else rep.read_data = store[row * STRIDE + col];
        end
        default: rep.status = ST_IGNORED;
      endcase
      due_replies.push_back(rep);
    endfunction

    task flag_mismatch(input string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Compare one delivered reply with the oldest one owed.
    task match_reply(input logic [7:0] read_data, input logic status);
      reply_t rep;
      if (due_replies.size() == 0) begin
        flag_mismatch($sformatf("reply with nothing owed (data %02h status %0b)",
                                read_data, status));
      end else begin
        rep = due_replies.pop_front();
        if (read_data !== rep.read_data)
          flag_mismatch($sformatf("request %0d op %0d: read_data %02h, want %02h",
                                  rep.seq, rep.op, read_data, rep.read_data));
        if (status !== rep.status)
          flag_mismatch($sformatf("request %0d op %0d: status %0b, want %0b",
                                  rep.seq, rep.op, status, rep.status));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // col[8:0], row[16:9], value[24:17], restart[25], zero[31:26]
  logic [IN_TDATA_W-1:0]  in_tdata;
  // op[2:0]
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // read_data[7:0]
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status[0]
  logic [OUT_TUSER_W-1:0] out_tuser;

  lcd_frame_mirror mirror = new();

  // Idling knobs: chance in percent that a burst of idle cycles starts, per side.
  int  src_gap_pct  = 25;
  int  sink_gap_pct = 25;
  // Set for the closing stretch: both sides run flat out.
  bit  quiet        = 1'b0;

  memory_lcd_frame_buffer #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT),
    .STRIDE(STRIDE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest correct run (every request waiting out the
  // longest gap and stall, plus a full sweep for each clear).
  initial begin
    #8_000_000;
    $display("tb_memory_lcd_frame_buffer: errors");
    $finish;
  end

  // Sample every delivered reply at the edge that moves it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.match_reply(out_tdata, out_tuser[0]);
  end

  // Result side: stall in random bursts, run free in between.
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < sink_gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one request and hold it until the block takes it. Leave tvalid high
  // so that a back-to-back request never lowers and raises it in one step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [8:0] col,
                              input logic [7:0] row, input logic [7:0] value,
                              input logic restart);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, restart, value, row, col};
    do @(posedge clk); while (!in_tready);
    mirror.take_request(op, col, row, value, restart);
  endtask

  // Sometimes drop tvalid for a burst of idle cycles before the next request.
  task automatic pace();
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed reply has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Rows: mostly the first few lines so that reads land on fresh writes.
  function automatic logic [7:0] pick_row();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(0, 3));
    if (r < 7) return 8'($urandom_range(0, HEIGHT - 1));
    if (r < 8) return 8'(HEIGHT - 1);
    return 8'($urandom_range(HEIGHT, 255));
  endfunction

  // Columns against the bound of the op in hand: low, anywhere, the edge, beyond.
  function automatic logic [8:0] pick_col(input int bound);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 9'($urandom_range(0, 15));
    if (r < 7) return 9'($urandom_range(0, bound - 1));
    if (r < 8) return 9'(bound - 1);
    return 9'($urandom_range(bound, 511));
  endfunction

  task automatic random_request();
    logic [OP_W-1:0] op;
    logic [8:0]      col;
    logic [7:0]      row;
    logic [7:0]      value;
    logic            restart;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = OP_PIXEL;
    else if (pick < 45) op = OP_BYTE;
    else if (pick < 70) op = OP_READ;
    else if (pick < 95) op = OP_LOAD;
    else                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    row     = pick_row();
    value   = 8'($urandom);
    restart = ($urandom_range(0, 15) == 0);
    case (op)
      OP_PIXEL: begin
        col = pick_col(WIDTH);
        if ($urandom_range(0, 1) == 0) value = 8'h00;
      end
      OP_BYTE: col = pick_col(PIX_BYTES);
      OP_READ: col = pick_col(STRIDE);
      default: col = 9'($urandom);
    endcase
    pace();
    send_request(op, col, row, value, restart);
  endtask

  task automatic random_read();
    pace();
    send_request(OP_READ, 9'($urandom_range(0, STRIDE - 1)),
                 8'($urandom_range(0, HEIGHT - 1)), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_CLEAR;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: clear first so that nothing read is ever undefined.
    send_request(OP_CLEAR, 9'd0, 8'd0, 8'd0, 1'b0);
    // Header bytes of the first line, line number of the last, last byte of the store.
    send_request(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0);
    send_request(OP_READ, 9'd1, 8'd0, 8'd0, 1'b0);
    send_request(OP_READ, 9'd1, 8'(HEIGHT - 1), 8'd0, 1'b0);
    send_request(OP_READ, 9'(STRIDE - 1), 8'(HEIGHT - 1), 8'd0, 1'b0);
    // Reads out of range.
    send_request(OP_READ, 9'(STRIDE), 8'd0, 8'd0, 1'b0);
    send_request(OP_READ, 9'd0, 8'(HEIGHT), 8'd0, 1'b0);
    send_request(OP_READ, 9'd511, 8'd255, 8'hFF, 1'b1);
    // Pixels at both corners, then out of range either way.
    send_request(OP_PIXEL, 9'd0, 8'd0, 8'h00, 1'b0);
    send_request(OP_PIXEL, 9'(WIDTH - 1), 8'(HEIGHT - 1), 8'h01, 1'b0);
    send_request(OP_PIXEL, 9'(WIDTH), 8'd0, 8'hFF, 1'b0);
    send_request(OP_PIXEL, 9'd0, 8'(HEIGHT), 8'hFF, 1'b0);
    send_request(OP_READ, 9'(HDR_BYTES), 8'd0, 8'd0, 1'b0);
    // Whole bytes at both ends of the pixel area, then past its end.
    send_request(OP_BYTE, 9'd0, 8'd0, 8'h00, 1'b0);
    send_request(OP_BYTE, 9'(PIX_BYTES - 1), 8'(HEIGHT - 1), 8'hA5, 1'b0);
    send_request(OP_BYTE, 9'(PIX_BYTES), 8'd0, 8'h5A, 1'b0);
    send_request(OP_READ, 9'(STRIDE - 1), 8'(HEIGHT - 1), 8'd0, 1'b0);
    // Loads from a restarted cursor, read back reversed.
    send_request(OP_LOAD, 9'd0, 8'd0, 8'h01, 1'b1);
    send_request(OP_LOAD, 9'd0, 8'd0, 8'hFE, 1'b0);
    send_request(OP_READ, 9'(HDR_BYTES), 8'd0, 8'd0, 1'b0);
    send_request(OP_READ, 9'(HDR_BYTES + 1), 8'd0, 8'd0, 1'b0);
    // Undefined op codes.
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      send_request(OP_W'(c), 9'd0, 8'd0, 8'd0, 1'b0);

    // Random mix with bursty idling on both sides.
    repeat (300) random_request();

    // Pause until everything is back, then load a little over two lines from a
    // restarted cursor so that it wraps twice; sprinkle reads to catch the
    // reversed bytes.
    drain();
    src_gap_pct  = 10;
    sink_gap_pct = 10;
    send_request(OP_LOAD, 9'd0, 8'd0, 8'($urandom), 1'b1);
    repeat (2 * PIX_BYTES + 8) begin
      pace();
      send_request(OP_LOAD, 9'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      if ($urandom_range(0, 9) == 0) random_read();
    end

    // Read back across the frame without idling on the sender.
    src_gap_pct = 0;
    repeat (60) random_read();

    // Fresh frame, then more random traffic with heavier stalls.
    drain();
    src_gap_pct  = 40;
    sink_gap_pct = 40;
    send_request(OP_CLEAR, 9'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    repeat (200) random_request();

    // Closing stretch: no idling anywhere.
    quiet = 1'b1;
    repeat (120) random_request();

    drain();
    repeat (16) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb_memory_lcd_frame_buffer: clean");
    end else begin
      $display("tb_memory_lcd_frame_buffer: errors");
    end
    $finish;
  end

endmodule
